// ===== sv/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, codes and defaults for the MLFQ demote and boost table.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  // Fixed field widths
  localparam int NUM_LEVELS  = 4;
  localparam int LEVEL_W     = 2;
  localparam int ENTRY_IDX_W = 6;
  localparam int SLICE_W     = 16;
  localparam int TICK_W      = 32;
  localparam int USED_W      = 16;
  localparam int BCOUNT_W    = 7;
  localparam int REG_IDX_W   = 3;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  // Defaults for top level parameters
  localparam int DEF_NUM_ENTRIES = 64;
  localparam int DEF_COUNT_BITS  = 16;

  localparam logic [BCOUNT_W-1:0] BCOUNT_MAX = '1;

  // Item modes
  localparam logic [1:0] MODE_CHARGE    = 2'd0;
  localparam logic [1:0] MODE_BOOST     = 2'd1;
  localparam logic [1:0] MODE_LIFECYCLE = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  // Lifecycle classes
  localparam logic [1:0] LC_UNUSED = 2'd0;
  localparam logic [1:0] LC_LIVE   = 2'd1;
  localparam logic [1:0] LC_ZOMBIE = 2'd2;
  localparam logic [1:0] LC_KEEP   = 2'd3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_QUANTUM0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT0   = 3'd4;

  localparam logic [NUM_LEVELS-1:0][SLICE_W-1:0] QUANTUM_RESET =
    {16'd8, 16'd4, 16'd2, 16'd1};
  localparam logic [NUM_LEVELS-1:0][SLICE_W-1:0] LIMIT_RESET =
    {16'd32, 16'd16, 16'd8, 16'd4};

  typedef struct packed {
    logic [1:0]             mode;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [1:0]             lifecycle_class;
    logic [TICK_W-1:0]      current_tick;
  } item_t;

  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] result_entry;
    logic [LEVEL_W-1:0]     new_priority;
    logic [SLICE_W-1:0]     slice_left;
    logic [USED_W-1:0]      level_ticks_used;
    logic                   charged;
    logic                   demoted;
    logic [BCOUNT_W-1:0]    boosted_count;
  } result_t;

  // Configuration seen by the update logic
  typedef struct packed {
    logic [NUM_LEVELS-1:0][SLICE_W-1:0] quantum;
    logic [NUM_LEVELS-1:0][SLICE_W-1:0] limit;
  } cfg_t;

  // Fixed part of one table entry
  typedef struct packed {
    logic [1:0]         lifecycle;
    logic [LEVEL_W-1:0] level;
    logic [SLICE_W-1:0] slice;
    logic [TICK_W-1:0]  stamp;
  } entry_hdr_t;

endpackage

// ===== sv/mlfq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// mlfq_entry_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module mlfq_entry_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mlfq_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mlfq_cfg_regs
// APB register bank for per-level quantum and allotment limit.
// ----------------------------------------------------------------------------
module mlfq_cfg_regs
  import mlfq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_xfer;
  logic [SLICE_W-1:0]   rd_val;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_xfer = psel && penable && pwrite;

  // Hold register values, update on a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quantum <= QUANTUM_RESET;
      cfg.limit   <= LIMIT_RESET;
    end else if (wr_xfer) begin
      if (reg_idx < REG_LIMIT0) begin
        cfg.quantum[reg_idx[1:0]] <= pwdata[SLICE_W-1:0];
      end else begin
        cfg.limit[reg_idx[1:0]] <= pwdata[SLICE_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (reg_idx < REG_LIMIT0) begin
      rd_val = cfg.quantum[reg_idx[1:0]];
    end else begin
      rd_val = cfg.limit[reg_idx[1:0]];
    end
    prdata = PDATA_W'(rd_val);
  end

endmodule

// ===== sv/mlfq_entry_update.sv =====
// ----------------------------------------------------------------------------
// mlfq_entry_update
// Modify step of the read-modify-write: charge, lifecycle and boost of one
// entry, plus the result for single-entry items.
// ----------------------------------------------------------------------------
module mlfq_entry_update
  import mlfq_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  item_t                                 item,
  input  logic                                  walk,
  input  cfg_t                                  cfg,
  input  entry_hdr_t                            hdr_old,
  input  logic [NUM_LEVELS-1:0][COUNT_BITS-1:0] cnt_old,
  output entry_hdr_t                            hdr_new,
  output logic [NUM_LEVELS-1:0][COUNT_BITS-1:0] cnt_new,
  output logic                                  wr,
  output result_t                               res
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [LEVEL_W-1:0]    LEVEL_LOW = LEVEL_W'(NUM_LEVELS - 1);

  logic                  out_of_range;
  logic [LEVEL_W-1:0]    lvl;
  logic [LEVEL_W-1:0]    lvl_down;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] bump;
  logic                  demote;
  logic                  idle_entry;

  assign out_of_range = 32'(item.entry_index) >= NUM_ENTRIES;
  assign lvl          = hdr_old.level;
  assign lvl_down     = lvl + LEVEL_W'(1);
  assign cur          = cnt_old[lvl];
  assign bump         = (cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1);
  assign demote       = (32'(bump) >= 32'(cfg.limit[lvl])) && (lvl != LEVEL_LOW);
  assign idle_entry   = (hdr_old.lifecycle == LC_UNUSED) ||
                        (hdr_old.lifecycle == LC_ZOMBIE);

  always_comb begin
    hdr_new = hdr_old;
    cnt_new = cnt_old;
    wr      = 1'b0;
    res     = '0;
    if (walk) begin
      // Raise any entry that is not unused and lies below the top level
      if ((hdr_old.lifecycle != LC_UNUSED) && (lvl != '0)) begin
        wr            = 1'b1;
        hdr_new.level = '0;
        hdr_new.slice = cfg.quantum[0];
        hdr_new.stamp = item.current_tick;
        cnt_new       = '0;
      end
    end else if (out_of_range && (item.mode != MODE_NONE)) begin
      res.result_entry = item.entry_index;
    end else begin
      case (item.mode)
        MODE_CHARGE: begin
          res.result_entry     = item.entry_index;
          res.new_priority     = lvl;
          res.slice_left       = hdr_old.slice;
          res.level_ticks_used = USED_W'(cur);
          if (!idle_entry) begin
            wr                   = 1'b1;
            cnt_new[lvl]         = bump;
            res.level_ticks_used = USED_W'(bump);
            res.charged          = 1'b1;
            // Drop one level and reload the slice once the allotment is spent
            if (demote) begin
              hdr_new.level    = lvl_down;
              hdr_new.slice    = cfg.quantum[lvl_down];
              res.new_priority = lvl_down;
              res.slice_left   = cfg.quantum[lvl_down];
              res.demoted      = 1'b1;
            end
          end
        end
        MODE_LIFECYCLE: begin
          if (item.lifecycle_class != LC_KEEP) begin
            wr                = 1'b1;
            hdr_new.lifecycle = item.lifecycle_class;
          end
          res.result_entry     = item.entry_index;
          res.new_priority     = lvl;
          res.slice_left       = hdr_old.slice;
          res.level_ticks_used = USED_W'(cur);
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

endmodule

// ===== sv/mlfq_demote_and_boost_table.sv =====
// Charge and lifecycle items: entry read, then modify/write.
// Boost items: one entry per cycle over the table.
// One item is in work at a time; the next is taken once the result is
// registered, while that result may still wait for the output transfer.
// After reset the table is cleared entry by entry, items held off.
// Configuration registers take their reset values at once.
// ----------------------------------------------------------------------------
// mlfq_demote_and_boost_table
// Top level: item sequencer around the entry memory and config registers.
// ----------------------------------------------------------------------------
module mlfq_demote_and_boost_table
  import mlfq_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W  = NUM_LEVELS * COUNT_BITS;
  localparam int WORD_W = $bits(entry_hdr_t) + CNT_W;
  localparam logic [AW-1:0] LAST = AW'(NUM_ENTRIES - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_BOOST, S_FINISH} state_t;

  state_t              state;
  logic [AW-1:0]       ptr;
  item_t               item_q;
  logic [BCOUNT_W-1:0] boost_cnt;

  cfg_t                                  cfg;
  logic                                  mem_we;
  logic [AW-1:0]                         mem_waddr;
  logic [WORD_W-1:0]                     mem_wdata;
  logic                                  mem_re;
  logic [AW-1:0]                         mem_raddr;
  logic [WORD_W-1:0]                     mem_rdata;
  entry_hdr_t                            hdr_old;
  entry_hdr_t                            hdr_new;
  logic [NUM_LEVELS-1:0][COUNT_BITS-1:0] cnt_old;
  logic [NUM_LEVELS-1:0][COUNT_BITS-1:0] cnt_new;
  logic                                  upd_wr;
  result_t                               upd_res;
  logic                                  in_xfer;
  logic                                  out_free;
  logic                                  walk;
  logic                                  last;
  logic                                  res_load;
  result_t                               result_next;

  assign item_ready = (state == S_IDLE);
  assign in_xfer    = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign walk       = (state == S_BOOST);
  assign last       = (ptr == LAST);
  assign res_load   = ((state == S_EXEC) || (state == S_FINISH)) && out_free;

  mlfq_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mlfq_entry_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign hdr_old = entry_hdr_t'(mem_rdata[WORD_W-1:CNT_W]);
  assign cnt_old = mem_rdata[CNT_W-1:0];

  mlfq_entry_update #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_update (
    .item    (item_q),
    .walk    (walk),
    .cfg     (cfg),
    .hdr_old (hdr_old),
    .cnt_old (cnt_old),
    .hdr_new (hdr_new),
    .cnt_new (cnt_new),
    .wr      (upd_wr),
    .res     (upd_res)
  );

  // Memory read: entry of a new item, or the next entry of a boost walk
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ptr + AW'(1);
    if (in_xfer) begin
      mem_re    = 1'b1;
      mem_raddr = (item.mode == MODE_BOOST) ? '0 : AW'(item.entry_index);
    end else if (walk && !last) begin
      mem_re = 1'b1;
    end
  end

  // Memory write: clearing sweep, single-entry update or boost step
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = {hdr_new, cnt_new};
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_EXEC: begin
        mem_we    = out_free && upd_wr;
        mem_waddr = AW'(item_q.entry_index);
      end
      S_BOOST: begin
        mem_we = upd_wr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Next result: boost summary, or the single-entry result
  always_comb begin
    result_next = upd_res;
    if (state == S_FINISH) begin
      result_next               = '0;
      result_next.slice_left    = cfg.quantum[0];
      result_next.boosted_count = boost_cnt;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_q <= item;
    end
  end

  // Sequencer, walk pointer, boost count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ptr          <= '0;
      boost_cnt    <= '0;
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
        result       <= result_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          ptr <= ptr + AW'(1);
          if (last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            ptr       <= '0;
            boost_cnt <= '0;
            state     <= (item.mode == MODE_BOOST) ? S_BOOST : S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_BOOST: begin
          if (upd_wr && (boost_cnt != BCOUNT_MAX)) begin
            boost_cnt <= boost_cnt + BCOUNT_W'(1);
          end
          ptr <= ptr + AW'(1);
          if (last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !item_ready)
    else $error("item taken in the cycle after an accept");

  // The boost count never runs ahead of the entries walked so far
  a_boost_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_BOOST) |-> (32'(boost_cnt) <= 32'(ptr)))
    else $error("boost count exceeds walked entries");

  // A new result appears only out of the update or boost finish states
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_EXEC || $past(state) == S_FINISH))
    else $error("result raised outside of a finishing state");

endmodule
